### sv/mes_pkg.sv
// ============================================================================
// mes_pkg: shared types and constants of the escape-time shader
// Widths, fixed-point format, shade codes, register indexes and the
// command/status structs between the controller and the datapath.
// ============================================================================
package mes_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int FRACTION_BITS   = 28;
    localparam int COUNT_WIDTH     = 16;
    localparam int PROD_WIDTH      = 2 * COORD_WIDTH;
    localparam int WIDE_WIDTH      = PROD_WIDTH + 1;
    localparam int SHADE_WIDTH     = 3;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = COUNT_WIDTH;

    localparam int IN_TDATA_WIDTH  = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS        = COUNT_WIDTH + 1 + SHADE_WIDTH;
    localparam int OUT_TDATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [WIDE_WIDTH-1:0]  wide_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;
    typedef logic [SHADE_WIDTH-1:0]        shade_t;
    typedef logic [CFG_INDEX_WIDTH-1:0]    cfg_index_t;
    typedef logic [CFG_DATA_WIDTH-1:0]     cfg_data_t;

    // |z| bounds in the wide product/sum format
    localparam wide_t TWO_WIDE  = wide_t'(1) <<< (FRACTION_BITS + 1);
    localparam wide_t FOUR_WIDE = wide_t'(1) <<< (2 * FRACTION_BITS + 2);

    localparam shade_t SHADE_WHITE      = shade_t'(0);
    localparam shade_t SHADE_LIGHT_GRAY = shade_t'(1);
    localparam shade_t SHADE_GRAY       = shade_t'(2);
    localparam shade_t SHADE_DARK_GRAY  = shade_t'(3);
    localparam shade_t SHADE_BLACK      = shade_t'(4);

    localparam cfg_index_t REG_ITERATION_LIMIT = cfg_index_t'(0);
    localparam cfg_index_t REG_SHADING_ON      = cfg_index_t'(1);

    localparam count_t LIMIT_RESET   = count_t'(256);
    localparam logic   SHADING_RESET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_STEP,
        ST_FLUSH
    } mes_state_t;

    typedef struct packed {
        logic load;      // capture c, start a new point
        logic mul;       // register the three products of z
        logic step;      // escape checks and z update
        logic out_load;  // move the finished result to the output register
    } mes_cmd_t;

    typedef struct packed {
        logic done;      // the current step ends the point
        logic out_free;  // output register can take a result this cycle
    } mes_status_t;

endpackage

### sv/mes_ctrl.sv
// ============================================================================
// mes_ctrl: iteration sequencer
// Walks each point through multiply and step cycles until the datapath
// reports the end, then hands the result over to the output register.
// ============================================================================
module mes_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mes_pkg::mes_status_t status,
    output mes_pkg::mes_cmd_t   cmd
);
    import mes_pkg::*;

    mes_state_t state_reg;
    mes_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = status.done ? ST_FLUSH : ST_MUL;
            end
            ST_FLUSH:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/mes_datapath.sv
// ============================================================================
// mes_datapath: z = z*z + c arithmetic, escape tests and result register
// Three registered 32x32 products per iteration, then the step: magnitude
// test on the products, new z with floor scaling, band shading at the end.
// ============================================================================
module mes_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mes_pkg::mes_cmd_t    cmd,
    input  mes_pkg::coord_t      c_real,
    input  mes_pkg::coord_t      c_imag,
    input  mes_pkg::count_t      iteration_limit,
    input  logic                 shading_on,
    output mes_pkg::mes_status_t status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output mes_pkg::count_t      iteration_count,
    output logic                 escaped,
    output mes_pkg::shade_t      shade_level
);
    import mes_pkg::*;

    coord_t cx_reg, cy_reg, x_reg, y_reg;
    prod_t  xx_reg, yy_reg, xy_reg;
    count_t count_reg;
    logic   first_reg, esc_reg;
    count_t out_count_reg;
    logic   out_esc_reg;
    shade_t out_shade_reg;
    logic   out_valid_reg;

    wide_t  diff, mag, tx_w, ty_w;
    logic   in_range, r_ge4, chk, esc_r, stop_lim, run;
    count_t quarter1, quarter2, quarter3;
    logic [COUNT_WIDTH+1:0] limit_x3;
    shade_t shade_next;

    // step arithmetic on the registered products
    always_comb
    begin
        diff  = wide_t'(xx_reg) - wide_t'(yy_reg);
        mag   = wide_t'(xx_reg) + wide_t'(yy_reg);
        tx_w  = (diff >>> FRACTION_BITS) + wide_t'(cx_reg);
        ty_w  = (wide_t'(xy_reg) >>> (FRACTION_BITS - 1)) + wide_t'(cy_reg);
        in_range = (tx_w < TWO_WIDE) && (tx_w > -TWO_WIDE)
                && (ty_w < TWO_WIDE) && (ty_w > -TWO_WIDE);
        r_ge4 = (mag >= FOUR_WIDE);
        // products of the starting point are not tested
        chk      = !first_reg;
        esc_r    = chk && r_ge4;
        stop_lim = chk && !r_ge4 && (count_reg >= iteration_limit);
        run      = !esc_r && !stop_lim;
    end

    assign status.done     = esc_r || stop_lim || !in_range;
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg    <= c_real;
            cy_reg    <= c_imag;
            x_reg     <= c_real;
            y_reg     <= c_imag;
            count_reg <= '0;
            first_reg <= 1'b1;
            esc_reg   <= 1'b0;
        end
        if (cmd.mul)
        begin
            xx_reg <= prod_t'(x_reg) * prod_t'(x_reg);
            yy_reg <= prod_t'(y_reg) * prod_t'(y_reg);
            xy_reg <= prod_t'(x_reg) * prod_t'(y_reg);
        end
        if (cmd.step)
        begin
            if (esc_r)
            begin
                esc_reg <= 1'b1;
            end
            else if (run)
            begin
                count_reg <= count_reg + count_t'(1);
                first_reg <= 1'b0;
                if (!in_range)
                begin
                    esc_reg <= 1'b1;
                end
                else
                begin
                    x_reg <= coord_t'(tx_w);
                    y_reg <= coord_t'(ty_w);
                end
            end
        end
    end

    // quarter bands of the limit
    always_comb
    begin
        limit_x3 = {2'b00, iteration_limit} + {1'b0, iteration_limit, 1'b0};
        quarter1 = iteration_limit >> 2;
        quarter2 = iteration_limit >> 1;
        quarter3 = limit_x3[COUNT_WIDTH+1:2];
        priority if (!esc_reg)
            shade_next = SHADE_BLACK;
        else if (!shading_on)
            shade_next = SHADE_WHITE;
        else if (count_reg < quarter1)
            shade_next = SHADE_WHITE;
        else if (count_reg < quarter2)
            shade_next = SHADE_LIGHT_GRAY;
        else if (count_reg < quarter3)
            shade_next = SHADE_GRAY;
        else if (count_reg < iteration_limit)
            shade_next = SHADE_DARK_GRAY;
        else
            shade_next = SHADE_BLACK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_count_reg <= count_reg;
            out_esc_reg   <= esc_reg;
            out_shade_reg <= shade_next;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign iteration_count = out_count_reg;
    assign escaped         = out_esc_reg;
    assign shade_level     = out_shade_reg;

endmodule

### sv/mandelbrot_escape_shader_top.sv
// Sequence: each step of a point is a product-register state, then a step
//   state. The step that ends the point counts an iteration when a part of
//   the new z reaches 2, but not when |z|^2 or the limit ends the point.
// Points: one point at a time; the next point is taken once the result has
//   moved to the output register, even while it waits.
// Reset: rst_n clears the sequencer and the output valid at once, and sets
//   iteration_limit to 256 and shading_on to 1.
// ============================================================================
// mandelbrot_escape_shader_top: escape-time iteration and shading of a point
// Streaming in/out, register write channel, sequencer plus datapath.
// ============================================================================
module mandelbrot_escape_shader_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // s_tdata, from bit 0: c_real[31:0], c_imag[31:0]
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [mes_pkg::IN_TDATA_WIDTH-1:0]     s_tdata,
    // m_tdata, from bit 0: iteration_count[15:0], escaped, shade_level[2:0],
    // then zero padding
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [mes_pkg::OUT_TDATA_WIDTH-1:0]    m_tdata,
    // register write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  mes_pkg::cfg_index_t                    cfg_index,
    input  mes_pkg::cfg_data_t                     cfg_data
);
    import mes_pkg::*;

    count_t      limit_reg;
    logic        shading_reg;
    mes_cmd_t    cmd;
    mes_status_t status;
    coord_t      c_real, c_imag;
    count_t      iteration_count;
    logic        escaped;
    shade_t      shade_level;

    // Register writes are always taken; indexes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            shading_reg <= SHADING_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_ITERATION_LIMIT)
            begin
                limit_reg <= count_t'(cfg_data);
            end
            else if (cfg_index == REG_SHADING_ON)
            begin
                shading_reg <= cfg_data[0];
            end
        end
    end

    // Unpack the input transfer
    assign c_real = coord_t'(s_tdata[COORD_WIDTH-1:0]);
    assign c_imag = coord_t'(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);

    mes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mes_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .iteration_limit (limit_reg),
        .shading_on      (shading_reg),
        .status          (status),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .iteration_count (iteration_count),
        .escaped         (escaped),
        .shade_level     (shade_level)
    );

    // Pack the result transfer, zero padded to whole bytes
    assign m_tdata = OUT_TDATA_WIDTH'({shade_level, escaped, iteration_count});

    // At least one iteration always runs
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> iteration_count != '0)
        else $error("result with zero iteration count");

    // A point that stays bounded is always black
    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !escaped) |-> shade_level == SHADE_BLACK)
        else $error("bounded point not shaded black");

    // Only the five defined shades appear
    a_shade_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (shade_level == SHADE_WHITE || shade_level == SHADE_LIGHT_GRAY
                      || shade_level == SHADE_GRAY || shade_level == SHADE_DARK_GRAY
                      || shade_level == SHADE_BLACK))
        else $error("shade code out of range");

    // The count never passes the limit unless the limit is zero
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && limit_reg != '0) |-> iteration_count <= limit_reg)
        else $error("iteration count beyond the limit");

endmodule
